// ===== rtl/sdog_pkg.sv =====
// Shared types, constants and helper functions of the spherical octree point encoder.
`timescale 1ns / 1ps
package sdog_pkg;

    localparam int MAX_LEVELS = 20;
    localparam int COORD_BITS = 32;
    localparam int ANGLE_W    = 32;
    localparam int LEVEL_W    = 5;
    localparam int OCTANT_W   = 3;
    localparam int DIGIT_W    = 3;
    localparam int DIGITS_W   = 60;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] GRID_RADIUS_RESET = 32'h8000_0000;

    typedef enum logic [2:0] {
        KIND_SG = 3'b001,
        KIND_LG = 3'b010,
        KIND_NG = 3'b100
    } t_kind;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] latitude;
        logic signed [ANGLE_W-1:0] longitude;
        logic [ANGLE_W-1:0]        radius;
        logic [LEVEL_W-1:0]        levels;
    } t_point_in;

    typedef struct packed {
        logic [OCTANT_W-1:0] octant;
        logic [DIGITS_W-1:0] child_digits;
        logic [LEVEL_W-1:0]  digit_count;
    } t_code_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] lat;
        logic [COORD_BITS-1:0] lon;
        logic [COORD_BITS-1:0] rad;
        logic [COORD_BITS-1:0] lat_lo;
        logic [COORD_BITS-1:0] lat_hi;
        logic [COORD_BITS-1:0] lon_lo;
        logic [COORD_BITS-1:0] lon_hi;
        logic [COORD_BITS-1:0] rad_lo;
        logic [COORD_BITS-1:0] rad_hi;
        t_kind                 kind;
        logic [OCTANT_W-1:0]   octant;
        logic [DIGITS_W-1:0]   digits;
        logic [LEVEL_W-1:0]    count;
    } t_cell;

    // Aligns a 32-bit magnitude to the interval format: left shift when the format
    // is wider, truncating right shift when it is narrower.
    function automatic logic [COORD_BITS-1:0] to_coord(input logic [ANGLE_W-1:0] v);
        logic [COORD_BITS+ANGLE_W-1:0] w;
        w = {v, COORD_BITS'(0)};
        return w[COORD_BITS+ANGLE_W-1 -: COORD_BITS];
    endfunction

    function automatic logic [COORD_BITS-1:0] midpoint(input logic [COORD_BITS-1:0] lo,
                                                       input logic [COORD_BITS-1:0] hi);
        logic [COORD_BITS:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        return s[COORD_BITS:1];
    endfunction

endpackage

// ===== rtl/sphere_octree_point_encoder.sv =====
// Top level of the spherical octree point encoder: entry stage, row of level cells, register.
//
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_in_data  (t_point_in)
// out       output     o_out_valid / i_out_ready    o_out_data (t_code_out)
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_data (grid radius)
//
// An item passes the entry stage and then one cell per level, each with its own register.
// The whole row advances together: unless stalled, one item enters and one leaves each cycle.
// The last cell's register holds the result; while it waits, the row stands still.
// Reset clears the valid bits of every stage and sets the grid radius to 2^31.
// Both input ports are held off during reset; the configuration port is ready otherwise.
`timescale 1ns / 1ps
module sphere_octree_point_encoder
    import sdog_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_point_in          i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_code_out          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ANGLE_W-1:0] i_cfg_data
);

    logic [ANGLE_W-1:0] r_grid_radius;
    logic               en;
    logic               stage_valid [MAX_LEVELS+1];
    t_cell              stage_cell  [MAX_LEVELS+1];

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_radius <= GRID_RADIUS_RESET;
        end else if (i_cfg_valid) begin
            r_grid_radius <= i_cfg_data;
        end
    end

    assign en         = !stage_valid[MAX_LEVELS] || i_out_ready;
    assign o_in_ready = en && i_rst_n;

    sdog_setup u_setup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_in_valid),
        .i_point       (i_in_data),
        .i_grid_radius (r_grid_radius),
        .o_valid       (stage_valid[0]),
        .o_cell        (stage_cell[0])
    );

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
        sdog_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_level (LEVEL_W'(g)),
            .i_valid (stage_valid[g]),
            .i_cell  (stage_cell[g]),
            .o_valid (stage_valid[g+1]),
            .o_cell  (stage_cell[g+1])
        );
    end

    assign o_out_valid             = stage_valid[MAX_LEVELS];
    assign o_out_data.octant       = stage_cell[MAX_LEVELS].octant;
    assign o_out_data.child_digits = stage_cell[MAX_LEVELS].digits;
    assign o_out_data.digit_count  = stage_cell[MAX_LEVELS].count;

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.digit_count <= LEVEL_W'(MAX_LEVELS)))
        else $error("digit count above the level limit");

    a_unused_digits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.child_digits >> (DIGIT_W * o_out_data.digit_count)) == '0))
        else $error("digits beyond the digit count are not zero");

    a_first_digit_sg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.digit_count != '0)) |->
            (o_out_data.child_digits[DIGIT_W-1:0] <= 3'd3))
        else $error("first child digit outside the four children of the root cell");

endmodule

// ===== rtl/sdog_setup.sv =====
// Entry stage: octant digit, magnitudes, level saturation and the starting intervals.
`timescale 1ns / 1ps
module sdog_setup
    import sdog_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_point_in          i_point,
    input  logic [ANGLE_W-1:0] i_grid_radius,
    output logic               o_valid,
    output t_cell              o_cell
);

    logic               r_valid;
    t_cell              r_cell;
    t_cell              n_cell;
    logic [ANGLE_W-1:0] lat_raw;
    logic [ANGLE_W-1:0] lon_raw;
    logic [ANGLE_W-1:0] lat_m;
    logic [ANGLE_W-1:0] lon_m;
    logic               far_half;

    always_comb begin
        lat_raw = i_point.latitude;
        lon_raw = i_point.longitude;
        lat_m = lat_raw[ANGLE_W-1] ? (~lat_raw + 1'b1) : lat_raw;
        lon_m = lon_raw[ANGLE_W-1] ? (~lon_raw + 1'b1) : lon_raw;
        if (lat_m > QUARTER_TURN) begin
            lat_m = QUARTER_TURN;
        end
        far_half = (lon_m > QUARTER_TURN);

        n_cell.lat    = to_coord(lat_m);
        n_cell.lon    = to_coord(lon_m);
        n_cell.rad    = to_coord(i_point.radius);
        n_cell.lat_lo = '0;
        n_cell.lat_hi = to_coord(QUARTER_TURN);
        n_cell.rad_lo = '0;
        n_cell.rad_hi = to_coord(i_grid_radius);
        if (far_half) begin
            n_cell.lon_lo = to_coord(QUARTER_TURN);
            n_cell.lon_hi = to_coord(HALF_TURN);
        end else begin
            n_cell.lon_lo = '0;
            n_cell.lon_hi = to_coord(QUARTER_TURN);
        end
        n_cell.kind   = KIND_SG;
        n_cell.octant = {lat_raw[ANGLE_W-1], lon_raw[ANGLE_W-1], far_half};
        n_cell.digits = '0;
        if (i_point.levels > LEVEL_W'(MAX_LEVELS)) begin
            n_cell.count = LEVEL_W'(MAX_LEVELS);
        end else begin
            n_cell.count = i_point.levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// ===== rtl/sdog_cell.sv =====
// Subdivision cell: halves intervals, appends its child digit if its level < count.
`timescale 1ns / 1ps
module sdog_cell
    import sdog_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic               i_valid,
    input  t_cell              i_cell,
    output logic               o_valid,
    output t_cell              o_cell
);

    logic                  r_valid;
    t_cell                 r_cell;
    t_cell                 n_cell;
    logic [COORD_BITS-1:0] mlat;
    logic [COORD_BITS-1:0] mlon;
    logic [COORD_BITS-1:0] mrad;
    logic                  outer;
    logic                  upper_lat;
    logic                  upper_lon;
    logic [DIGIT_W-1:0]    d;

    always_comb begin
        n_cell    = i_cell;
        mlat      = midpoint(i_cell.lat_lo, i_cell.lat_hi);
        mlon      = midpoint(i_cell.lon_lo, i_cell.lon_hi);
        mrad      = midpoint(i_cell.rad_lo, i_cell.rad_hi);
        outer     = (i_cell.rad > mrad);
        upper_lat = (i_cell.lat >= mlat);
        upper_lon = (i_cell.lon >= mlon);
        d         = '0;

        if (i_level < i_cell.count) begin
            if (outer) begin
                n_cell.rad_lo = mrad;
            end else begin
                n_cell.rad_hi = mrad;
            end
            case (i_cell.kind)
                KIND_NG: begin
                    d = {!outer, upper_lat, upper_lon};
                    if (upper_lat) begin
                        n_cell.lat_lo = mlat;
                    end else begin
                        n_cell.lat_hi = mlat;
                    end
                    if (upper_lon) begin
                        n_cell.lon_lo = mlon;
                    end else begin
                        n_cell.lon_hi = mlon;
                    end
                end
                KIND_LG: begin
                    d = outer ? 3'd0 : 3'd3;
                    if (upper_lat) begin
                        d = d + 3'd2;
                        n_cell.lat_lo = mlat;
                    end else begin
                        n_cell.lat_hi = mlat;
                        n_cell.kind   = KIND_NG;
                        if (upper_lon) begin
                            d = d + 3'd1;
                            n_cell.lon_lo = mlon;
                        end else begin
                            n_cell.lon_hi = mlon;
                        end
                    end
                end
                default: begin
                    if (!outer) begin
                        d = 3'd3;
                    end else if (upper_lat) begin
                        d = 3'd2;
                        n_cell.lat_lo = mlat;
                        n_cell.kind   = KIND_LG;
                    end else begin
                        n_cell.lat_hi = mlat;
                        n_cell.kind   = KIND_NG;
                        if (upper_lon) begin
                            d = 3'd1;
                            n_cell.lon_lo = mlon;
                        end else begin
                            d = 3'd0;
                            n_cell.lon_hi = mlon;
                        end
                    end
                end
            endcase
            for (int j = 0; j < MAX_LEVELS; j++) begin
                if (i_level == LEVEL_W'(j)) begin
                    n_cell.digits[DIGIT_W*j +: DIGIT_W] = d;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule
